// File: design/mhfd_pkg.sv
// ----------------------------------------------------------------------------
// mhfd_pkg: shared types and constants for the magic-header frame deframer
// Frame layout sizes, register indexes, phase and result-kind encodings, length saturation.
// ----------------------------------------------------------------------------
package mhfd_pkg;

  // Frame layout
  localparam int MAX_PAYLOAD   = 4096;  // hard ceiling on payload length
  localparam int INFO_BYTES    = 12;    // skipped information bytes
  localparam int MAGIC_LEN     = 4;
  localparam int LEN_BYTES     = 4;
  localparam int CNT_W         = 6;
  localparam int LEN_FIELD_W   = 13;
  localparam int LEN_FIELD_MAX = (1 << LEN_FIELD_W) - 1;

  // Configuration register indexes
  localparam logic [1:0] REG_HEAD  = 2'd0;
  localparam logic [1:0] REG_TAIL  = 2'd1;
  localparam logic [1:0] REG_MAGIC = 2'd2;
  localparam logic [1:0] REG_MAXP  = 2'd3;

  // Receive phase, one-hot
  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_MAGIC = 8'b0000_0010,
    PH_SEQ   = 8'b0000_0100,
    PH_CMD   = 8'b0000_1000,
    PH_INFO  = 8'b0001_0000,
    PH_LEN   = 8'b0010_0000,
    PH_DATA  = 8'b0100_0000,
    PH_TAIL  = 8'b1000_0000
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_BAD = 2'd2,
    KIND_LEN_ERR = 2'd3
  } kind_t;

  // Saturate a 32-bit length into the reported length field
  function automatic logic [LEN_FIELD_W-1:0] sat_len(input logic [31:0] v);
    if (v > 32'(LEN_FIELD_MAX)) begin
      return LEN_FIELD_W'(LEN_FIELD_MAX);
    end
    return v[LEN_FIELD_W-1:0];
  endfunction

endpackage

// File: design/magic_header_frame_deframer.sv
// ----------------------------------------------------------------------------
// magic_header_frame_deframer: byte-stream frame extractor
// Hunts for head + magic, latches sequence/command, skips info bytes, reads a
// little-endian length, streams payload bytes and reports the tail check.
// ----------------------------------------------------------------------------
//
//  channel | direction | width               | contents
//  --------+-----------+---------------------+------------------------------
//  in_     | slave     | tdata 8             | in_byte
//  out_    | master    | tdata 40, tuser 2,  | payload/end/error items
//          |           | tlast 1             |
//  cfg_    | write     | index 2, wdata 32   | head, tail, magic, max_payload
//
// One byte per cycle while in_tready is high: each accepted byte updates the
// phase state and, when it produces a result, loads the output register in
// the same cycle. The output register is the only stall point; in_tready is
// high whenever that register is empty or being drained this cycle.
// Reset (rst_n low, synchronous) returns to hunting and loads register
// defaults; no clearing pass is needed.
//
module magic_header_frame_deframer
  import mhfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [7:0] data_byte, [15:8] frame_seq,
                                   // [23:16] frame_cmd, [36:24] frame_length,
                                   // [39:37] zero
  output logic [1:0]  out_tuser,   // [1:0] kind
  output logic        out_tlast,   // last
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Configuration registers
  logic [7:0]             head_byte_r;
  logic [7:0]             tail_byte_r;
  logic [31:0]            magic_word_r;
  logic [LEN_FIELD_W-1:0] max_payload_r;

  // Frame state
  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic [7:0]             seq_r, seq_nxt;
  logic [7:0]             cmd_r, cmd_nxt;
  logic [31:0]            len_r, len_nxt;
  logic [LEN_FIELD_W-1:0] left_r, left_nxt;

  // Output register
  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [7:0]             out_data_r;
  logic [7:0]             out_seq_r;
  logic [7:0]             out_cmd_r;
  logic [LEN_FIELD_W-1:0] out_len_r;
  logic                   out_last_r;

  // Per-byte result
  logic                   emit;
  kind_t                  emit_kind;
  logic [7:0]             emit_data;
  logic                   emit_last;

  logic                   accept;
  logic [7:0]             b;
  logic [CNT_W-1:0]       fcnt_inc;
  logic [7:0]             magic_exp;
  logic [31:0]            len_acc;
  logic [31:0]            limit;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign fcnt_inc  = fcnt_r + CNT_W'(1);
  assign magic_exp = magic_word_r[{fcnt_r[1:0], 3'b000} +: 8];

  // Length byte merged into the running little-endian value
  assign len_acc = ((fcnt_r == '0) ? 32'd0 : len_r) |
                   (32'(b) << {fcnt_r[1:0], 3'b000});

  // Effective limit: smaller of register and hard ceiling
  assign limit = (32'(MAX_PAYLOAD) < 32'(max_payload_r)) ? 32'(MAX_PAYLOAD)
                                                         : 32'(max_payload_r);

  // Phase step
  always_comb begin
    phase_nxt = phase_r;
    fcnt_nxt  = fcnt_r;
    seq_nxt   = seq_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    emit_kind = KIND_DATA;
    emit_data = 8'd0;
    emit_last = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (b == head_byte_r) begin
          phase_nxt = PH_MAGIC;
          fcnt_nxt  = '0;
        end
      end
      PH_MAGIC: begin
        if (b == magic_exp) begin
          fcnt_nxt = fcnt_inc;
          if (fcnt_inc >= CNT_W'(MAGIC_LEN)) begin
            phase_nxt = PH_SEQ;
            fcnt_nxt  = '0;
          end
        end else begin
          // mismatching byte may itself be a new head
          fcnt_nxt  = '0;
          phase_nxt = (b == head_byte_r) ? PH_MAGIC : PH_HUNT;
        end
      end
      PH_SEQ: begin
        seq_nxt   = b;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = b;
        fcnt_nxt  = '0;
        phase_nxt = (INFO_BYTES == 0) ? PH_LEN : PH_INFO;
      end
      PH_INFO: begin
        fcnt_nxt = fcnt_inc;
        if (fcnt_inc >= CNT_W'(INFO_BYTES)) begin
          phase_nxt = PH_LEN;
          fcnt_nxt  = '0;
        end
      end
      PH_LEN: begin
        len_nxt  = len_acc;
        fcnt_nxt = fcnt_inc;
        if (fcnt_inc >= CNT_W'(LEN_BYTES)) begin
          fcnt_nxt = '0;
          if (len_acc > limit) begin
            phase_nxt = PH_HUNT;
            emit      = 1'b1;
            emit_kind = KIND_LEN_ERR;
            emit_last = 1'b1;
          end else begin
            left_nxt  = len_acc[LEN_FIELD_W-1:0];
            phase_nxt = (len_acc[LEN_FIELD_W-1:0] == '0) ? PH_TAIL : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        emit      = 1'b1;
        emit_data = b;
        left_nxt  = left_r - LEN_FIELD_W'(1);
        if (left_nxt == '0) begin
          phase_nxt = PH_TAIL;
        end
      end
      PH_TAIL: begin
        emit      = 1'b1;
        emit_kind = (b == tail_byte_r) ? KIND_END_OK : KIND_END_BAD;
        emit_last = 1'b1;
        phase_nxt = PH_HUNT;
        fcnt_nxt  = '0;
      end
      default: begin
        phase_nxt = PH_HUNT;
        fcnt_nxt  = '0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_byte_r   <= 8'd0;
      tail_byte_r   <= 8'd0;
      magic_word_r  <= 32'd0;
      max_payload_r <= LEN_FIELD_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD:  head_byte_r   <= cfg_wdata[7:0];
        REG_TAIL:  tail_byte_r   <= cfg_wdata[7:0];
        REG_MAGIC: magic_word_r  <= cfg_wdata;
        REG_MAXP:  max_payload_r <= cfg_wdata[LEN_FIELD_W-1:0];
        default:   ;
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      fcnt_r  <= '0;
      seq_r   <= 8'd0;
      cmd_r   <= 8'd0;
      len_r   <= 32'd0;
      left_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fcnt_r  <= fcnt_nxt;
      seq_r   <= seq_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind_r <= emit_kind;
      out_data_r <= emit_data;
      out_seq_r  <= seq_r;
      out_cmd_r  <= cmd_r;
      out_len_r  <= sat_len(len_nxt);
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_len_r, out_cmd_r, out_seq_r, out_data_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r != KIND_DATA)))
    else $error("tlast disagrees with result kind");

  a_nonpayload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_DATA) |-> (out_data_r == 8'd0))
    else $error("non-payload item carries data");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_DATA) |-> (out_len_r != '0))
    else $error("payload byte from a zero-length frame");

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (left_r != '0))
    else $error("payload phase with no bytes left");

endmodule
